FILE: hw/rtl/fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg: shared types for the fraction reducer
// Start and status groups passed between the sequencer and its arithmetic
// units.
// ----------------------------------------------------------------------------
package fr_pkg;

    // Command into an iterative unit
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    // Status out of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

FILE: hw/rtl/fraction_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reducer: reduce a signed fraction by its common divisor
//
//   channel  | dir | tdata fields (low bit up)        | tuser / tlast
//   s_axis   | in  | num_in, den_in, zero pad to byte | none
//   m_axis   | out | num_out, den_out, zero pad       | none
//
// One fraction at a time. The binary gcd does one shift or one subtract per
// cycle. The shared restoring divider then divides the numerator and then
// the denominator by the gcd. When neither value is a positive number of at
// least 2 the pair passes straight to the output register.
// s_axis_tready is high only while the sequencer is idle; a finished
// result waits in the output register while the next fraction is taken.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module fraction_reducer #(
    parameter  int DATA_WIDTH  = 32,
    localparam int TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_WIDTH-1:0] s_axis_tdata,   // num_in, den_in
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_WIDTH-1:0] m_axis_tdata    // num_out, den_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_DIVD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic [DATA_WIDTH-1:0] g_reg, g_next;
    logic [DATA_WIDTH-1:0] res_num_reg, res_num_next;
    logic [DATA_WIDTH-1:0] res_den_reg, res_den_next;
    logic [DATA_WIDTH-1:0] out_num_reg, out_num_next;
    logic [DATA_WIDTH-1:0] out_den_reg, out_den_next;
    logic                  out_valid_reg, out_valid_next;

    logic [DATA_WIDTH-1:0] in_num;
    logic [DATA_WIDTH-1:0] in_den;
    logic [DATA_WIDTH-1:0] in_num_mag;
    logic [DATA_WIDTH-1:0] in_den_mag;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic                  in_big;
    logic                  in_fire;
    logic                  out_load;

    fr_pkg::unit_ctl_t     gcd_ctl;
    fr_pkg::unit_sts_t     gcd_sts;
    logic [DATA_WIDTH-1:0] gcd_val;
    fr_pkg::unit_ctl_t     div_ctl;
    fr_pkg::unit_sts_t     div_sts;
    logic [DATA_WIDTH-1:0] div_dividend;
    logic [DATA_WIDTH-1:0] div_divisor;
    logic [DATA_WIDTH-1:0] div_quo;

    // Unpack the input beat and take magnitudes
    assign in_num     = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_den     = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_num_mag = in_num[DATA_WIDTH-1] ? (~in_num + 1'b1) : in_num;
    assign in_den_mag = in_den[DATA_WIDTH-1] ? (~in_den + 1'b1) : in_den;
    assign num_mag    = num_reg[DATA_WIDTH-1] ? (~num_reg + 1'b1) : num_reg;
    assign den_mag    = den_reg[DATA_WIDTH-1] ? (~den_reg + 1'b1) : den_reg;

    // Reduce only when one value is positive and at least 2
    assign in_big = (!in_num[DATA_WIDTH-1] && (|in_num[DATA_WIDTH-2:1])) ||
                    (!in_den[DATA_WIDTH-1] && (|in_den[DATA_WIDTH-2:1]));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // Unit starts
    assign gcd_ctl.start = in_fire && in_big;
    assign div_ctl.start = ((state_reg == ST_GCD) && gcd_sts.done) ||
                           ((state_reg == ST_DIVN) && div_sts.done);
    assign div_dividend  = (state_reg == ST_GCD) ? num_mag : den_mag;
    assign div_divisor   = (state_reg == ST_GCD) ? gcd_val : g_reg;

    fr_gcd #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (gcd_ctl),
        .a_in  (in_num_mag),
        .b_in  (in_den_mag),
        .sts   (gcd_sts),
        .gcd   (gcd_val)
    );

    fr_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        g_next         = g_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_valid_next = out_valid_reg;

        // Drop the output beat once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    num_next     = in_num;
                    den_next     = in_den;
                    res_num_next = in_num;
                    res_den_next = in_den;
                    state_next   = in_big ? ST_GCD : ST_OUT;
                end
            end
            ST_GCD:
            begin
                if (gcd_sts.done)
                begin
                    g_next     = gcd_val;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (div_sts.done)
                begin
                    res_num_next = num_reg[DATA_WIDTH-1] ? (~div_quo + 1'b1) : div_quo;
                    state_next   = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (div_sts.done)
                begin
                    res_den_next = den_reg[DATA_WIDTH-1] ? (~div_quo + 1'b1) : div_quo;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_num_next   = res_num_reg;
                    out_den_next   = res_den_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        g_reg       <= g_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_WIDTH'({out_den_reg, out_num_reg});

endmodule

FILE: hw/rtl/fr_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_gcd: iterative binary greatest common divisor
// One shift or one compare-and-subtract per cycle over two unsigned
// magnitudes; common factors of two are counted and restored at the end.
// gcd(0, x) = x.
// ----------------------------------------------------------------------------
module fr_gcd #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fr_pkg::unit_ctl_t       ctl,
    input  logic [DATA_WIDTH-1:0]   a_in,
    input  logic [DATA_WIDTH-1:0]   b_in,
    output fr_pkg::unit_sts_t       sts,
    output logic [DATA_WIDTH-1:0]   gcd
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [DATA_WIDTH-1:0] g_reg, g_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic                  a_ge_b;
    logic [DATA_WIDTH-1:0] big_op;
    logic [DATA_WIDTH-1:0] small_op;
    logic [DATA_WIDTH-1:0] diff;

    // Shared compare and subtract
    assign a_ge_b   = (a_reg >= b_reg);
    assign big_op   = a_ge_b ? a_reg : b_reg;
    assign small_op = a_ge_b ? b_reg : a_reg;
    assign diff     = big_op - small_op;

    // One reduction step per cycle
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            priority if (a_reg == '0)
            begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + CNT_W'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_ge_b)
            begin
                a_next = diff;
            end
            else
            begin
                b_next = diff;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands and result
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign gcd      = g_reg;

endmodule

FILE: hw/rtl/fr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_div: restoring unsigned divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fr_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fr_pkg::unit_ctl_t       ctl,
    input  logic [DATA_WIDTH-1:0]   dividend,
    input  logic [DATA_WIDTH-1:0]   divisor,
    output fr_pkg::unit_sts_t       sts,
    output logic [DATA_WIDTH-1:0]   quotient
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   trial;
    logic                  fits;

    // Shared trial subtract
    assign rem_sh = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    // One quotient bit per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DATA_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DATA_WIDTH-2:0], fits};
            rem_next = fits ? trial[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule
